/* hw/rtl/swm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window minimum core.
// ----------------------------------------------------------------------------
package swm_pkg;

    // deepest window and cell count
    localparam int MAX_WINDOW = 1024;

    // field widths
    localparam int DATA_W = 32;
    localparam int CFG_W  = 11;
    // an age runs up to MAX_WINDOW itself
    localparam int AGE_W  = $clog2(MAX_WINDOW) + 1;

    // one queue entry held by a cell
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic [AGE_W-1:0]         age;
    } entry_t;

    // what a cell shows its neighbors
    typedef struct packed {
        entry_t entry;
        logic   ge;     // stored value not smaller than the new sample
        logic   keep;   // entry stays in the queue on this word
    } cell_link_t;

    // control broadcast to every cell
    typedef struct packed {
        logic                     step;    // a sample word is taken
        logic                     shift;   // front entry leaves, all move one forward
        logic signed [DATA_W-1:0] sample;
    } cell_ctl_t;

endpackage

/* hw/rtl/swm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the monotonic queue: holds an entry, compares it with the
// incoming sample and moves data forward from its back neighbor.
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  swm_pkg::cell_ctl_t  ctl,
    input  swm_pkg::cell_link_t next_link,   // neighbor toward the back
    input  logic                prev_keep,   // neighbor toward the front stays
    output swm_pkg::cell_link_t link
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [swm_pkg::DATA_W-1:0] value_reg;
    logic signed [swm_pkg::DATA_W-1:0] value_next;
    logic [swm_pkg::AGE_W-1:0]         age_reg;
    logic [swm_pkg::AGE_W-1:0]         age_next;

    logic                              own_ge;
    swm_pkg::entry_t                   sel_entry;
    logic                              sel_ge;
    logic                              keep;

    // own comparison against the new sample
    assign own_ge = (value_reg >= ctl.sample);

    // entry after an optional front drop
    always_comb begin
        if (ctl.shift) begin
            sel_entry = next_link.entry;
            sel_ge    = next_link.ge;
        end else begin
            sel_entry.valid = valid_reg;
            sel_entry.value = value_reg;
            sel_entry.age   = age_reg;
            sel_ge          = own_ge;
        end
    end

    // entries not smaller than the sample leave at the back
    assign keep = sel_entry.valid && !sel_ge;

    // next contents: kept entry, appended sample, or empty
    always_comb begin
        valid_next = sel_entry.valid;
        value_next = sel_entry.value;
        age_next   = sel_entry.age;
        if (ctl.step) begin
            if (keep) begin
                valid_next = 1'b1;
                age_next   = sel_entry.age + swm_pkg::AGE_W'(1);
            end else if (prev_keep) begin
                valid_next = 1'b1;
                value_next = ctl.sample;
                age_next   = swm_pkg::AGE_W'(1);
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign link.entry.valid = valid_reg;
    assign link.entry.value = value_reg;
    assign link.entry.age   = age_reg;
    assign link.ge          = own_ge;
    assign link.keep        = keep;

endmodule

/* hw/rtl/sliding_window_minimum_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_minimum_core
// Running minimum of the last window_length signed samples.
// ----------------------------------------------------------------------------
// Each accepted sample word yields one result word: the minimum of the most
// recent window_length samples, the current one included (or of all samples
// so far before a full window has been seen). A window length of zero acts
// as one, and lengths above 1024 act as 1024. The queue is a row of 1024
// cells, front at cell 0; every cell compares its entry with the new sample
// in the same cycle, so one sample is taken per clock while s_ready is high.
// After the window is made shorter, each entry beyond the first that has
// left the window is dropped alone with s_ready low. The result sits in an
// output register, so a new sample is taken only while m_ready is high or the
// register is empty. cfg_ready is always high; write only while idle.
// ----------------------------------------------------------------------------
module sliding_window_minimum_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]         cfg_data,
    // sample words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [swm_pkg::DATA_W-1:0] s_sample,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [swm_pkg::DATA_W-1:0] m_window_min
);

    localparam int N = swm_pkg::MAX_WINDOW;

    logic [swm_pkg::CFG_W-1:0]         window_length_reg;
    logic [swm_pkg::AGE_W-1:0]         len_eff;
    logic                              m_valid_reg;
    logic signed [swm_pkg::DATA_W-1:0] m_window_min_reg;

    swm_pkg::cell_link_t               link [N+1];
    swm_pkg::cell_ctl_t                ctl;
    logic                              stale0;
    logic                              stale1;
    logic                              drop_only;
    logic                              step;
    logic signed [swm_pkg::DATA_W-1:0] front_value;
    logic signed [swm_pkg::DATA_W-1:0] result;

    // window length register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= swm_pkg::CFG_W'(1);
        end else if (cfg_valid) begin
            window_length_reg <= cfg_data;
        end
    end

    // clamp to 1..MAX_WINDOW
    always_comb begin
        if (window_length_reg == '0) begin
            len_eff = swm_pkg::AGE_W'(1);
        end else if (window_length_reg > swm_pkg::CFG_W'(N)) begin
            len_eff = swm_pkg::AGE_W'(N);
        end else begin
            len_eff = swm_pkg::AGE_W'(window_length_reg);
        end
    end

    // front entries that have aged out of the window, drained only while a
    // sample word waits so that the length in force at its step decides
    assign stale0    = link[0].entry.valid && (link[0].entry.age >= len_eff);
    assign stale1    = link[1].entry.valid && (link[1].entry.age >= len_eff);
    assign drop_only = s_valid && stale0 && stale1;

    // handshake
    assign s_ready = !drop_only && (!m_valid_reg || m_ready);
    assign step    = s_valid && s_ready;

    assign ctl.step   = step;
    assign ctl.shift  = drop_only || (step && stale0);
    assign ctl.sample = s_sample;

    // empty slot behind the last cell
    assign link[N].entry.valid = 1'b0;
    assign link[N].entry.value = '0;
    assign link[N].entry.age   = '0;
    assign link[N].ge          = 1'b1;
    assign link[N].keep        = 1'b0;

    // row of cells
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic prev_keep;
        if (i == 0) begin : g_first
            assign prev_keep = 1'b1;
        end else begin : g_rest
            assign prev_keep = link[i-1].keep;
        end

        swm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .next_link (link[i+1]),
            .prev_keep (prev_keep),
            .link      (link[i])
        );
    end

    // new front of the queue is the minimum
    assign front_value = stale0 ? link[1].entry.value : link[0].entry.value;
    assign result      = link[0].keep ? front_value : s_sample;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_window_min_reg <= result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_window_min = m_window_min_reg;

endmodule
